// ===== hw/rtl/mau_pkg.sv =====
// Types and constants shared by the modular arithmetic unit.
// Residue arithmetic is modulo the prime 1000000007.
// No dependencies.
`timescale 1ns / 1ps

package mau_pkg;

    localparam logic [29:0] MOD_P      = 30'd1000000007;
    localparam logic [31:0] MOD_P_X2   = 32'd2000000014;
    localparam logic [30:0] FERMAT_EXP = 31'd1000000005;

    // Barrett factor floor(2^60 / MOD_P)
    localparam logic [63:0] MU_FULL    = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

    typedef logic [29:0] residue_t;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_POW = 3'd3,
        OP_DIV = 3'd4
    } opcode_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [29:0] operand_a;
        logic [29:0] operand_b;
        logic [30:0] exponent;
    } mau_in_t;

    typedef struct packed {
        logic [29:0] value;
        logic        is_equal;
        logic        is_less;
    } mau_out_t;

    typedef struct packed {
        logic     start;
        residue_t x;
        residue_t y;
    } mm_req_t;

    typedef struct packed {
        logic     done;
        residue_t value;
    } mm_rsp_t;

    typedef enum logic [2:0] {
        MM_IDLE,
        MM_EST,
        MM_QP,
        MM_SUB,
        MM_FIX
    } mm_state_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DISPATCH,
        CS_LOOP,
        CS_WAIT_ACC,
        CS_WAIT_SQ,
        CS_WAIT_FIN,
        CS_DONE
    } ctl_state_t;

endpackage

// ===== hw/rtl/mau_mulmod.sv =====
// Modular multiplier: one 32x32 multiplier shared over the product,
// the Barrett quotient estimate and the quotient times modulus.
// Depends on mau_pkg.
`timescale 1ns / 1ps

module mau_mulmod
    import mau_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  mm_req_t req,
    output mm_rsp_t rsp
);

    mm_state_t   state_reg, state_next;
    logic [59:0] prod_reg;
    logic [30:0] q_reg;
    logic [31:0] qp_reg;
    logic [31:0] r_reg;

    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;

    always_comb
    begin
        mul_x = {2'b00, req.x};
        mul_y = {2'b00, req.y};
        case (state_reg)
            MM_EST:
            begin
                mul_x = {1'b0, prod_reg[59:29]};
                mul_y = {1'b0, BARRETT_MU};
            end
            MM_QP:
            begin
                mul_x = {1'b0, q_reg};
                mul_y = {2'b00, MOD_P};
            end
            default:
            begin
                mul_x = {2'b00, req.x};
                mul_y = {2'b00, req.y};
            end
        endcase
    end

    assign mul_p = mul_x * mul_y;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MM_IDLE:  state_next = MM_IDLE;
            MM_EST:   state_next = MM_QP;
            MM_QP:    state_next = MM_SUB;
            MM_SUB:   state_next = MM_FIX;
            MM_FIX:   state_next = MM_IDLE;
            default:  state_next = MM_IDLE;
        endcase
        // a new request restarts the sequence from any phase
        if (req.start)
        begin
            state_next = MM_EST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= mul_p[59:0];
        end
        if (state_reg == MM_EST)
        begin
            q_reg <= mul_p[61:31];
        end
        if (state_reg == MM_QP)
        begin
            qp_reg <= mul_p[31:0];
        end
        if (state_reg == MM_SUB)
        begin
            // the estimate is short by at most two, so the remainder fits 32 bits
            r_reg <= prod_reg[31:0] - qp_reg;
        end
    end

    always_comb
    begin
        rsp.done = (state_reg == MM_FIX);
        if (r_reg >= MOD_P_X2)
        begin
            rsp.value = 30'(r_reg - MOD_P_X2);
        end
        else if (r_reg >= {2'b00, MOD_P})
        begin
            rsp.value = 30'(r_reg - {2'b00, MOD_P});
        end
        else
        begin
            rsp.value = r_reg[29:0];
        end
    end

endmodule

// ===== hw/rtl/modular_arithmetic_unit.sv =====
// Top level of the modular arithmetic unit: command sequencer, add and
// subtract logic, square-and-multiply control and the result register.
// Depends on mau_pkg and mau_mulmod.
//
//   channel  direction  payload    handshake
//   cmd      in         mau_in_t   cmd_valid / cmd_stall
//   res      out        mau_out_t  res_valid / res_stall
//
// Add, subtract and unused opcodes finish without the multiplier; multiply,
// divide and power are paced by the shared multiplier, power by the bit length
// and the set bits of the exponent, and a zero exponent takes no multiplication.
// One command is in work at a time; cmd_stall is high from accept until the
// result is registered at the output. Reset clears the sequencer and res_valid.
`timescale 1ns / 1ps

module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  mau_in_t  cmd,
    output logic     res_valid,
    input  logic     res_stall,
    output mau_out_t res
);

    ctl_state_t  state_reg, state_next;
    opcode_t     op_reg;
    residue_t    a_reg;
    residue_t    b_reg;
    residue_t    acc_reg, acc_next;
    residue_t    sq_reg, sq_next;
    residue_t    value_reg, value_next;
    logic [30:0] exp_reg, exp_next;
    logic        eq_reg;
    logic        lt_reg;
    logic        out_valid_reg;
    mau_out_t    out_reg;

    logic        accept;
    logic        load_out;
    residue_t    a_red;
    residue_t    b_red;
    logic [30:0] sum;
    mm_req_t     mm_req;
    mm_rsp_t     mm_rsp;

    mau_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    assign cmd_stall = (state_reg != CS_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign load_out  = (state_reg == CS_DONE) && (!out_valid_reg || !res_stall);

    // fields are below 2*MOD_P, so one subtraction reduces them
    assign a_red = (cmd.operand_a >= MOD_P) ? (cmd.operand_a - MOD_P) : cmd.operand_a;
    assign b_red = (cmd.operand_b >= MOD_P) ? (cmd.operand_b - MOD_P) : cmd.operand_b;

    assign sum = (op_reg == OP_ADD) ? ({1'b0, a_reg} + {1'b0, b_reg})
                                    : ({1'b0, a_reg} + {1'b0, MOD_P - b_reg});

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        exp_next   = exp_reg;
        value_next = value_reg;
        mm_req     = '{start: 1'b0, x: acc_reg, y: sq_reg};
        case (state_reg)
            CS_IDLE:
            begin
                if (accept)
                begin
                    state_next = CS_DISPATCH;
                    acc_next   = 30'd1;
                    if (cmd.opcode == OP_DIV)
                    begin
                        sq_next  = b_red;
                        exp_next = FERMAT_EXP;
                    end
                    else
                    begin
                        sq_next  = a_red;
                        exp_next = cmd.exponent;
                    end
                end
            end
            CS_DISPATCH:
            begin
                case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        value_next = (sum >= {1'b0, MOD_P}) ? 30'(sum - {1'b0, MOD_P})
                                                            : sum[29:0];
                        state_next = CS_DONE;
                    end
                    OP_MUL:
                    begin
                        mm_req     = '{start: 1'b1, x: a_reg, y: b_reg};
                        state_next = CS_WAIT_FIN;
                    end
                    OP_POW, OP_DIV:
                    begin
                        state_next = CS_LOOP;
                    end
                    default:
                    begin
                        value_next = '0;
                        state_next = CS_DONE;
                    end
                endcase
            end
            CS_LOOP:
            begin
                if (exp_reg == '0)
                begin
                    value_next = acc_reg;
                    if (op_reg == OP_DIV)
                    begin
                        mm_req     = '{start: 1'b1, x: acc_reg, y: a_reg};
                        state_next = CS_WAIT_FIN;
                    end
                    else
                    begin
                        state_next = CS_DONE;
                    end
                end
                else if (exp_reg[0])
                begin
                    mm_req     = '{start: 1'b1, x: acc_reg, y: sq_reg};
                    state_next = CS_WAIT_ACC;
                end
                else
                begin
                    mm_req     = '{start: 1'b1, x: sq_reg, y: sq_reg};
                    state_next = CS_WAIT_SQ;
                end
            end
            CS_WAIT_ACC:
            begin
                if (mm_rsp.done)
                begin
                    acc_next = mm_rsp.value;
                    if (exp_reg[30:1] == '0)
                    begin
                        // last set bit: drop the final squaring
                        exp_next   = '0;
                        state_next = CS_LOOP;
                    end
                    else
                    begin
                        mm_req     = '{start: 1'b1, x: sq_reg, y: sq_reg};
                        state_next = CS_WAIT_SQ;
                    end
                end
            end
            CS_WAIT_SQ:
            begin
                if (mm_rsp.done)
                begin
                    sq_next    = mm_rsp.value;
                    exp_next   = {1'b0, exp_reg[30:1]};
                    state_next = CS_LOOP;
                end
            end
            CS_WAIT_FIN:
            begin
                if (mm_rsp.done)
                begin
                    value_next = mm_rsp.value;
                    state_next = CS_DONE;
                end
            end
            CS_DONE:
            begin
                if (load_out)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= load_out || (out_valid_reg && res_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        exp_reg   <= exp_next;
        value_reg <= value_next;
        if (accept)
        begin
            op_reg <= cmd.opcode;
            a_reg  <= a_red;
            b_reg  <= b_red;
            // flags compare the raw fields
            eq_reg <= (cmd.operand_a == cmd.operand_b);
            lt_reg <= (cmd.operand_a < cmd.operand_b);
        end
        if (load_out)
        begin
            out_reg <= '{value: value_reg, is_equal: eq_reg, is_less: lt_reg};
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule
